@@ rtl/eafra_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// eafra_pkg
// Shared types, codes and constants of the elastic audio frame buffer.
// ----------------------------------------------------------------------------
package eafra_pkg;

  localparam int unsigned DEPTH_DEF     = 4096;
  localparam int unsigned CHANNELS_DEF  = 4;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned IN_CH     = 4;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned FILL_W    = 12;
  localparam int unsigned ADJ_W     = 17;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned CHUSED_W  = 3;
  localparam int unsigned APB_AW    = 4;
  localparam int unsigned APB_DW    = 32;

  localparam logic [FILL_W-1:0]   OPTIMAL_FILL_RST  = 12'd2048;
  localparam logic [GAIN_W-1:0]   ADJUST_GAIN_RST   = 16'd16;
  localparam logic [GAIN_W-1:0]   MAX_ADJUST_RST    = 16'd655;
  localparam logic [CHUSED_W-1:0] CHANNELS_USED_RST = 3'd2;
  localparam logic [FILL_W-1:0]   FILL_MAX          = 12'hFFF;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_PULL  = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_OPTIMAL_FILL  = 2'd0,
    REG_ADJUST_GAIN   = 2'd1,
    REG_MAX_ADJUST    = 2'd2,
    REG_CHANNELS_USED = 2'd3
  } reg_e;

  typedef struct packed {
    op_e                  op;
    logic                 batch_first;
    logic signed [15:0]   in_sample0;
    logic signed [15:0]   in_sample1;
    logic signed [15:0]   in_sample2;
    logic signed [15:0]   in_sample3;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0]   out_sample0;
    logic signed [15:0]   out_sample1;
    logic signed [15:0]   out_sample2;
    logic signed [15:0]   out_sample3;
    logic                 underrun;
    logic                 dropped;
    logic [FILL_W-1:0]    fill_level;
  } out_item_t;

  typedef struct packed {
    logic                    busy;
    logic signed [ADJ_W-1:0] speed_adjust;
  } adj_status_t;

endpackage
`default_nettype wire

@@ rtl/eafra_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// eafra_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface eafra_in_if;
  logic                 valid;
  logic                 ready;
  eafra_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface eafra_out_if;
  logic                 valid;
  logic                 ready;
  eafra_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/eafra_frame_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// eafra_frame_ram
// Single write port, single read port frame memory, registered read data.
// ----------------------------------------------------------------------------
module eafra_frame_ram #(
  parameter int unsigned DEPTH = eafra_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(eafra_pkg::DEPTH_DEF),
  parameter int unsigned DW    = 64
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ rtl/eafra_adjust.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// eafra_adjust
// Speed adjust update: fill error, gain multiply, clamp, each registered in turn.
// ----------------------------------------------------------------------------
module eafra_adjust #(
  parameter int unsigned IW = $clog2(eafra_pkg::DEPTH_DEF),
  parameter int unsigned FW = eafra_pkg::FILL_W
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic                                both_zero_i,
  input  wire logic [IW-1:0]                       fill_i,
  input  wire logic [eafra_pkg::FILL_W-1:0]        optimal_fill_i,
  input  wire logic [eafra_pkg::GAIN_W-1:0]        adjust_gain_i,
  input  wire logic [eafra_pkg::GAIN_W-1:0]        max_adjust_i,
  output eafra_pkg::adj_status_t                   status_o
);

  localparam int unsigned PRW = FW + 1 + eafra_pkg::GAIN_W + 1;

  logic                                 err_v_q;
  logic signed [FW:0]                   err_q, err_d;
  logic                                 prod_v_q;
  logic signed [PRW-1:0]                prod_q;
  logic signed [PRW-1:0]                lim;
  logic signed [eafra_pkg::ADJ_W-1:0]   adj_q, adj_d;

  always_comb begin
    if (both_zero_i) begin
      err_d = '0;
    end else begin
      err_d = signed'({1'b0, FW'(fill_i)}) - signed'({1'b0, FW'(optimal_fill_i)});
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      err_q <= err_d;
    end
    if (err_v_q) begin
      prod_q <= PRW'(err_q) * signed'(PRW'({1'b0, adjust_gain_i}));
    end
  end

  always_comb begin
    lim   = signed'(PRW'(max_adjust_i));
    adj_d = adj_q;
    if (prod_v_q) begin
      if (prod_q > lim) begin
        adj_d = eafra_pkg::ADJ_W'(lim);
      end else if (prod_q < -lim) begin
        adj_d = eafra_pkg::ADJ_W'(-lim);
      end else begin
        adj_d = eafra_pkg::ADJ_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_v_q  <= 1'b0;
      prod_v_q <= 1'b0;
      adj_q    <= '0;
    end else begin
      err_v_q  <= start_i;
      prod_v_q <= err_v_q;
      adj_q    <= adj_d;
    end
  end

  assign status_o.busy         = err_v_q | prod_v_q;
  assign status_o.speed_adjust = adj_q;

endmodule
`default_nettype wire

@@ rtl/elastic_audio_fifo_rate_adapt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// elastic_audio_fifo_rate_adapt
// Ring buffer of audio frames with fill-level driven read rate adjustment.
// ----------------------------------------------------------------------------
// a result passes the memory read stage and then the output register
// throughput: one item per cycle unless stalled by the output or the adjust;
// the frame memory port is used at most once per item; a batch-starting push
// holds off the next item while the gain multiply and clamp of the speed adjust
// complete; reset clears indices, phase and speed adjust and loads register
// defaults; the frame memory is not cleared and needs no clearing pass
module elastic_audio_fifo_rate_adapt #(
  parameter int unsigned DEPTH     = eafra_pkg::DEPTH_DEF,
  parameter int unsigned CHANNELS  = eafra_pkg::CHANNELS_DEF,
  parameter int unsigned FRAC_BITS = eafra_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  eafra_in_if.sink                           in_i,
  eafra_out_if.source                        out_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [eafra_pkg::APB_AW-1:0]  paddr,
  input  wire logic [eafra_pkg::APB_DW-1:0]  pwdata,
  output logic      [eafra_pkg::APB_DW-1:0]  prdata,
  output logic                               pready
);

  localparam int unsigned IW       = $clog2(DEPTH);
  localparam int unsigned STORE_CH = (CHANNELS < eafra_pkg::IN_CH) ? CHANNELS
                                                                   : eafra_pkg::IN_CH;
  localparam int unsigned DW       = STORE_CH * eafra_pkg::SAMPLE_W;
  localparam int unsigned FDW      = eafra_pkg::IN_CH * eafra_pkg::SAMPLE_W;
  localparam int unsigned FW       = (IW > eafra_pkg::FILL_W) ? IW : eafra_pkg::FILL_W;
  localparam int unsigned PW       = FRAC_BITS + 3;
  localparam int unsigned SH_L     = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int unsigned SH_R     = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam logic [IW-1:0] LAST_IDX  = IW'(DEPTH - 1);
  localparam logic [PW-1:0] PHASE_ONE = PW'(1) << FRAC_BITS;

  // configuration registers
  logic [eafra_pkg::FILL_W-1:0]   optimal_fill_q;
  logic [eafra_pkg::GAIN_W-1:0]   adjust_gain_q;
  logic [eafra_pkg::GAIN_W-1:0]   max_adjust_q;
  logic [eafra_pkg::CHUSED_W-1:0] channels_used_q;
  logic                           cfg_we;
  eafra_pkg::reg_e                cfg_sel;

  // index and phase state
  logic [IW-1:0]        wr_idx_q, wr_idx_d;
  logic [IW-1:0]        rd_idx_q, rd_idx_d;
  logic [FRAC_BITS-1:0] phase_q, phase_d;
  logic [IW-1:0]        fill_now;
  logic [IW:0]          fill_wrap;
  logic                 both_zero;

  // accept stage
  logic                 in_ready;
  logic                 accept;
  logic                 s2_free;
  logic                 is_push, is_pull, is_flush;
  logic [IW-1:0]        wr_next, rd_step1, rd_step2;
  logic                 full, empty;
  logic                 ram_we, ram_re;
  logic [FDW-1:0]       in_frame;
  logic [DW-1:0]        ram_rdata;
  logic signed [PW-1:0] scaled_adj;
  logic [PW-1:0]        phase_sum;
  logic [1:0]           steps;
  eafra_pkg::adj_status_t adj;

  // result stages
  logic                 s1_valid_q;
  logic                 s1_pull_q, s1_underrun_q, s1_dropped_q;
  logic                 out_valid_q;
  eafra_pkg::out_item_t out_data_q, out_data_d;
  logic [FDW-1:0]       rd_frame;
  logic [FW-1:0]        fill_ext;
  logic [eafra_pkg::SAMPLE_W-1:0] samp [eafra_pkg::IN_CH];

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_sel = eafra_pkg::reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      optimal_fill_q  <= eafra_pkg::OPTIMAL_FILL_RST;
      adjust_gain_q   <= eafra_pkg::ADJUST_GAIN_RST;
      max_adjust_q    <= eafra_pkg::MAX_ADJUST_RST;
      channels_used_q <= eafra_pkg::CHANNELS_USED_RST;
    end else if (cfg_we) begin
      case (cfg_sel)
        eafra_pkg::REG_OPTIMAL_FILL:  optimal_fill_q  <= pwdata[eafra_pkg::FILL_W-1:0];
        eafra_pkg::REG_ADJUST_GAIN:   adjust_gain_q   <= pwdata[eafra_pkg::GAIN_W-1:0];
        eafra_pkg::REG_MAX_ADJUST:    max_adjust_q    <= pwdata[eafra_pkg::GAIN_W-1:0];
        eafra_pkg::REG_CHANNELS_USED: channels_used_q <= pwdata[eafra_pkg::CHUSED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      eafra_pkg::REG_OPTIMAL_FILL:  prdata = eafra_pkg::APB_DW'(optimal_fill_q);
      eafra_pkg::REG_ADJUST_GAIN:   prdata = eafra_pkg::APB_DW'(adjust_gain_q);
      eafra_pkg::REG_MAX_ADJUST:    prdata = eafra_pkg::APB_DW'(max_adjust_q);
      eafra_pkg::REG_CHANNELS_USED: prdata = eafra_pkg::APB_DW'(channels_used_q);
      default:                      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // fill level, shared by the adjust update and the result stage
  // ---------------------------------------------------------------------------
  always_comb begin
    fill_wrap = {1'b0, wr_idx_q} + (IW + 1)'(DEPTH) - {1'b0, rd_idx_q};
    if (wr_idx_q >= rd_idx_q) begin
      fill_now = wr_idx_q - rd_idx_q;
    end else begin
      fill_now = fill_wrap[IW-1:0];
    end
  end

  assign both_zero = (wr_idx_q == '0) && (rd_idx_q == '0);

  // ---------------------------------------------------------------------------
  // accept stage
  // ---------------------------------------------------------------------------
  assign s2_free  = !out_valid_q || out_o.ready;
  assign in_ready = !adj.busy && (!s1_valid_q || s2_free);
  assign in_i.ready = in_ready;
  assign accept   = in_i.valid && in_ready;

  assign is_push  = accept && (in_i.data.op == eafra_pkg::OP_PUSH);
  assign is_pull  = accept && (in_i.data.op == eafra_pkg::OP_PULL);
  assign is_flush = accept && (in_i.data.op == eafra_pkg::OP_FLUSH);

  assign wr_next  = (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + 1'b1;
  assign rd_step1 = (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;
  // second step stops where the read side catches the write side
  assign rd_step2 = (rd_step1 == wr_idx_q) ? rd_step1
                  : ((rd_step1 == LAST_IDX) ? '0 : rd_step1 + 1'b1);

  assign full   = (wr_next == rd_idx_q);
  assign empty  = (wr_idx_q == rd_idx_q);
  assign ram_we = is_push && !full;
  assign ram_re = is_pull && !empty;

  assign in_frame = {in_i.data.in_sample3, in_i.data.in_sample2,
                     in_i.data.in_sample1, in_i.data.in_sample0};

  // speed adjust rescaled to the phase fraction, rounding towards minus infinity
  always_comb begin
    if (FRAC_BITS >= 16) begin
      scaled_adj = PW'(adj.speed_adjust) <<< SH_L;
    end else begin
      scaled_adj = PW'(adj.speed_adjust >>> SH_R);
    end
    phase_sum = PW'(phase_q) + PHASE_ONE + $unsigned(scaled_adj);
    steps     = phase_sum[FRAC_BITS+1:FRAC_BITS];
  end

  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    phase_d  = phase_q;
    if (ram_we) begin
      wr_idx_d = wr_next;
    end
    if (ram_re) begin
      phase_d = phase_sum[FRAC_BITS-1:0];
      case (steps)
        2'd0:    rd_idx_d = rd_idx_q;
        2'd1:    rd_idx_d = rd_step1;
        default: rd_idx_d = rd_step2;
      endcase
    end
    if (is_flush) begin
      wr_idx_d = '0;
      rd_idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      phase_q  <= '0;
    end else begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      phase_q  <= phase_d;
    end
  end

  eafra_adjust #(
    .IW (IW),
    .FW (FW)
  ) u_adjust (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (is_push && in_i.data.batch_first),
    .both_zero_i    (both_zero),
    .fill_i         (fill_now),
    .optimal_fill_i (optimal_fill_q),
    .adjust_gain_i  (adjust_gain_q),
    .max_adjust_i   (max_adjust_q),
    .status_o       (adj)
  );

  eafra_frame_ram #(
    .DEPTH (DEPTH),
    .AW    (IW),
    .DW    (DW)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q),
    .wdata_i (in_frame[DW-1:0]),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // result stage: memory read returns, then the output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s2_free) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pull_q     <= ram_re;
      s1_underrun_q <= is_pull && empty;
      s1_dropped_q  <= is_push && full;
    end
  end

  assign rd_frame = FDW'(ram_rdata);
  assign fill_ext = FW'(fill_now);

  // channels past channels_used give zero
  always_comb begin
    for (int k = 0; k < eafra_pkg::IN_CH; k++) begin
      if (s1_pull_q && (channels_used_q > eafra_pkg::CHUSED_W'(k))) begin
        samp[k] = rd_frame[k*eafra_pkg::SAMPLE_W +: eafra_pkg::SAMPLE_W];
      end else begin
        samp[k] = '0;
      end
    end
    out_data_d.out_sample0 = signed'(samp[0]);
    out_data_d.out_sample1 = signed'(samp[1]);
    out_data_d.out_sample2 = signed'(samp[2]);
    out_data_d.out_sample3 = signed'(samp[3]);
    out_data_d.underrun    = s1_underrun_q;
    out_data_d.dropped     = s1_dropped_q;
    if (fill_ext > FW'(eafra_pkg::FILL_MAX)) begin
      out_data_d.fill_level = eafra_pkg::FILL_MAX;
    end else begin
      out_data_d.fill_level = fill_ext[eafra_pkg::FILL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the elastic audio frame buffer. A queue of push,
// pull, flush and idle beats is driven through the input channel with random
// gaps, while results are taken with random back-pressure. Every result is
// compared field by field with a predictor that tracks the ring indices,
// speed adjust and read phase. Registers are set over APB between phases and
// read back.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned PTR_W          = $clog2(eafra_pkg::DEPTH_DEF);
  localparam longint      PHASE_ONE      = longint'(1) << eafra_pkg::FRAC_BITS_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned MAX_PRINTED    = 200;
  localparam int unsigned IN_CH          = eafra_pkg::IN_CH;
  localparam int unsigned SAMPLE_W       = eafra_pkg::SAMPLE_W;
  localparam int unsigned FRAME_W        = IN_CH * SAMPLE_W;

  logic                         clk;
  logic                         rst_n;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [eafra_pkg::APB_AW-1:0] paddr;
  logic [eafra_pkg::APB_DW-1:0] pwdata;
  logic [eafra_pkg::APB_DW-1:0] prdata;
  logic                         pready;

  eafra_in_if  in_ch ();
  eafra_out_if out_ch ();

  elastic_audio_fifo_rate_adapt dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predicted state of the ring
  logic [FRAME_W-1:0]             frame_mem [eafra_pkg::DEPTH_DEF];
  logic [PTR_W-1:0]               wr_ptr;
  logic [PTR_W-1:0]               rd_ptr;
  longint                         trim;
  longint                         phase_acc;
  logic [eafra_pkg::FILL_W-1:0]   cfg_target_fill;
  logic [eafra_pkg::GAIN_W-1:0]   cfg_gain;
  logic [eafra_pkg::GAIN_W-1:0]   cfg_trim_max;
  logic [eafra_pkg::CHUSED_W-1:0] cfg_ch_used;

  eafra_pkg::in_item_t    pending_beats [$];
  eafra_pkg::out_item_t   awaited_results [$];
  eafra_pkg::out_item_t   got_result;
  eafra_pkg::out_item_t   want_result;

  logic        in_taken;
  int unsigned gap_left;
  int unsigned hold_left;
  bit          held_long;
  bit          gaps_on;
  bit          stalls_on;
  int unsigned beats_accepted;
  int unsigned results_seen;
  int unsigned error_count;
  int unsigned quiet_cycles;

  always #6 clk = ~clk;

  function automatic eafra_pkg::out_item_t advance_buffer(eafra_pkg::in_item_t it);
    eafra_pkg::out_item_t res;
    logic [FRAME_W-1:0]   pulled;
    logic [PTR_W-1:0]     nxt;
    logic [PTR_W-1:0]     fill;
    longint               err;
    longint               prod;
    longint               lim;
    longint               steps;
    res    = '0;
    pulled = '0;
    case (it.op)
      eafra_pkg::OP_PUSH: begin
        if (it.batch_first) begin
          if (wr_ptr == '0 && rd_ptr == '0) begin
            trim = 0;
          end else begin
            fill = wr_ptr - rd_ptr;
            err  = longint'(fill) - longint'(cfg_target_fill);
            prod = err * longint'(cfg_gain);
            lim  = longint'(cfg_trim_max);
            if (prod > lim) prod = lim;
            if (prod < -lim) prod = -lim;
            trim = prod;
          end
        end
        nxt = wr_ptr + 1'b1;
        if (nxt != rd_ptr) begin
          frame_mem[wr_ptr] = {it.in_sample0, it.in_sample1, it.in_sample2, it.in_sample3};
          wr_ptr = nxt;
        end else begin
          res.dropped = 1'b1;
        end
      end
      eafra_pkg::OP_PULL: begin
        if (rd_ptr != wr_ptr) begin
          pulled = frame_mem[rd_ptr];
          for (int k = 0; k < IN_CH; k++)
            if (k >= int'(cfg_ch_used)) pulled[(IN_CH-1-k)*SAMPLE_W +: SAMPLE_W] = '0;
          phase_acc = phase_acc + PHASE_ONE + trim;
          steps     = phase_acc >> eafra_pkg::FRAC_BITS_DEF;
          phase_acc = phase_acc & (PHASE_ONE - 1);
          // read side never overtakes the write side
          while (steps > 0) begin
            if (rd_ptr != wr_ptr) rd_ptr = rd_ptr + 1'b1;
            steps--;
          end
        end else begin
          res.underrun = 1'b1;
        end
      end
      eafra_pkg::OP_FLUSH: begin
        wr_ptr = '0;
        rd_ptr = '0;
      end
      default: ;
    endcase
    {res.out_sample0, res.out_sample1, res.out_sample2, res.out_sample3} = pulled;
    fill           = wr_ptr - rd_ptr;
    res.fill_level = fill;
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [FRAME_W-1:0] random_frame();
    logic [FRAME_W-1:0] f;
    for (int k = 0; k < IN_CH; k++)
      case ($urandom_range(9))
        0:       f[k*SAMPLE_W +: SAMPLE_W] = 16'h8000;
        1:       f[k*SAMPLE_W +: SAMPLE_W] = 16'h7FFF;
        2:       f[k*SAMPLE_W +: SAMPLE_W] = '0;
        default: f[k*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom());
      endcase
    return f;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (error_count < MAX_PRINTED)
      $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
               results_seen, what, got, want);
    error_count++;
  endtask

  task automatic queue_beat(eafra_pkg::op_e op, logic first, logic [FRAME_W-1:0] samples);
    eafra_pkg::in_item_t it;
    it.op          = op;
    it.batch_first = first;
    {it.in_sample0, it.in_sample1, it.in_sample2, it.in_sample3} = samples;
    pending_beats.push_back(it);
  endtask

  // mostly batches of pushes followed by pulls, with stray beats mixed in
  task automatic queue_traffic(int unsigned n_beats, int unsigned push_max,
                               int unsigned pull_max);
    int unsigned    added;
    int unsigned    n;
    eafra_pkg::op_e op;
    added = 0;
    while (added < n_beats) begin
      if ($urandom_range(9) == 0) begin
        op = eafra_pkg::op_e'($urandom_range(3));
        queue_beat(op, 1'($urandom_range(1)), random_frame());
        if (op != eafra_pkg::OP_NOP) added++;
      end else begin
        n = $urandom_range(push_max, 1);
        for (int k = 0; k < n; k++)
          queue_beat(eafra_pkg::OP_PUSH, k == 0 && $urandom_range(4) != 0, random_frame());
        added += n;
        n = $urandom_range(pull_max);
        for (int k = 0; k < n; k++)
          queue_beat(eafra_pkg::OP_PULL, 1'($urandom_range(1)), random_frame());
        added += n;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_ch.valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(eafra_pkg::reg_e r, logic [eafra_pkg::APB_DW-1:0] value);
    logic [eafra_pkg::APB_DW-1:0] got;
    logic [eafra_pkg::APB_DW-1:0] stored;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (r)
      eafra_pkg::REG_OPTIMAL_FILL: begin
        cfg_target_fill = value[eafra_pkg::FILL_W-1:0];
        stored          = eafra_pkg::APB_DW'(cfg_target_fill);
      end
      eafra_pkg::REG_ADJUST_GAIN: begin
        cfg_gain = value[eafra_pkg::GAIN_W-1:0];
        stored   = eafra_pkg::APB_DW'(cfg_gain);
      end
      eafra_pkg::REG_MAX_ADJUST: begin
        cfg_trim_max = value[eafra_pkg::GAIN_W-1:0];
        stored       = eafra_pkg::APB_DW'(cfg_trim_max);
      end
      default: begin
        cfg_ch_used = value[eafra_pkg::CHUSED_W-1:0];
        stored      = eafra_pkg::APB_DW'(cfg_ch_used);
      end
    endcase
    // read back from the same address
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== stored) report_mismatch("register read back", {32'd0, got}, {32'd0, stored});
  endtask

  task automatic run_phase(logic [eafra_pkg::APB_DW-1:0] target,
                           logic [eafra_pkg::APB_DW-1:0] gain,
                           logic [eafra_pkg::APB_DW-1:0] lim,
                           logic [eafra_pkg::APB_DW-1:0] chans,
                           int unsigned n_beats, int unsigned push_max,
                           int unsigned pull_max, bit gaps, bit stalls);
    write_reg(eafra_pkg::REG_OPTIMAL_FILL, target);
    write_reg(eafra_pkg::REG_ADJUST_GAIN, gain);
    write_reg(eafra_pkg::REG_MAX_ADJUST, lim);
    write_reg(eafra_pkg::REG_CHANNELS_USED, chans);
    gaps_on   = gaps;
    stalls_on = stalls;
    queue_traffic(n_beats, push_max, pull_max);
    wait_drained();
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_ch.valid || in_taken) begin
        if (gap_left != 0) begin
          in_ch.valid <= 1'b0;
          gap_left    <= gap_left - 1;
        end else if (pending_beats.size() != 0) begin
          in_ch.data  <= pending_beats.pop_front();
          in_ch.valid <= 1'b1;
          if (gaps_on) gap_left <= pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure, with one long hold to fill the pipeline
  always @(negedge clk) begin
    if (rst_n) begin
      if (!held_long && beats_accepted >= 60) begin
        held_long    <= 1'b1;
        hold_left    <= LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else begin
        out_ch.ready <= 1'b1;
        if (stalls_on && $urandom_range(3) == 0) hold_left <= pick_gap();
      end
    end
  end

  // prediction and checking
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        awaited_results.push_back(advance_buffer(in_ch.data));
        beats_accepted <= beats_accepted + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got_result = out_ch.data;
        if (awaited_results.size() == 0) begin
          report_mismatch("result with nothing awaited", got_result[63:0], 64'd0);
        end else begin
          want_result = awaited_results.pop_front();
          if (got_result.out_sample0 !== want_result.out_sample0)
            report_mismatch("out_sample0", {48'd0, got_result.out_sample0},
                            {48'd0, want_result.out_sample0});
          if (got_result.out_sample1 !== want_result.out_sample1)
            report_mismatch("out_sample1", {48'd0, got_result.out_sample1},
                            {48'd0, want_result.out_sample1});
          if (got_result.out_sample2 !== want_result.out_sample2)
            report_mismatch("out_sample2", {48'd0, got_result.out_sample2},
                            {48'd0, want_result.out_sample2});
          if (got_result.out_sample3 !== want_result.out_sample3)
            report_mismatch("out_sample3", {48'd0, got_result.out_sample3},
                            {48'd0, want_result.out_sample3});
          if (got_result.underrun !== want_result.underrun)
            report_mismatch("underrun", {63'd0, got_result.underrun},
                            {63'd0, want_result.underrun});
          if (got_result.dropped !== want_result.dropped)
            report_mismatch("dropped", {63'd0, got_result.dropped},
                            {63'd0, want_result.dropped});
          if (got_result.fill_level !== want_result.fill_level)
            report_mismatch("fill_level", {52'd0, got_result.fill_level},
                            {52'd0, want_result.fill_level});
        end
        results_seen++;
      end
      in_taken <= in_ch.valid && in_ch.ready;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.data      = '0;
    out_ch.ready    = 1'b0;
    in_taken        = 1'b0;
    gap_left        = 0;
    hold_left       = 0;
    held_long       = 1'b0;
    gaps_on         = 1'b1;
    stalls_on       = 1'b1;
    beats_accepted  = 0;
    results_seen    = 0;
    error_count     = 0;
    quiet_cycles    = 0;
    wr_ptr          = '0;
    rd_ptr          = '0;
    trim            = 0;
    phase_acc       = 0;
    cfg_target_fill = eafra_pkg::OPTIMAL_FILL_RST;
    cfg_gain        = eafra_pkg::ADJUST_GAIN_RST;
    cfg_trim_max    = eafra_pkg::MAX_ADJUST_RST;
    cfg_ch_used     = eafra_pkg::CHANNELS_USED_RST;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed beats on reset settings
    queue_beat(eafra_pkg::OP_PULL, 1'b0, '0);
    // batch start with both indices at zero keeps the adjust at zero
    queue_beat(eafra_pkg::OP_PUSH, 1'b1, {16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF});
    queue_beat(eafra_pkg::OP_PUSH, 1'b0, {16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001});
    queue_beat(eafra_pkg::OP_PUSH, 1'b0, {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
    queue_beat(eafra_pkg::OP_NOP, 1'b1, {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
    queue_beat(eafra_pkg::OP_PULL, 1'b1, '1);
    queue_beat(eafra_pkg::OP_PULL, 1'b0, '0);
    queue_beat(eafra_pkg::OP_PULL, 1'b0, '0);
    queue_beat(eafra_pkg::OP_PULL, 1'b0, '0);
    queue_beat(eafra_pkg::OP_PUSH, 1'b0, random_frame());
    queue_beat(eafra_pkg::OP_PUSH, 1'b0, random_frame());
    queue_beat(eafra_pkg::OP_FLUSH, 1'b1, '1);
    queue_beat(eafra_pkg::OP_PULL, 1'b0, '0);
    queue_beat(eafra_pkg::OP_PUSH, 1'b1, random_frame());
    repeat (3) queue_beat(eafra_pkg::OP_PUSH, 1'b0, random_frame());
    // fill far below target: adjust clamps negative and pulls repeat frames
    queue_beat(eafra_pkg::OP_PUSH, 1'b1, random_frame());
    repeat (5) queue_beat(eafra_pkg::OP_PULL, 1'b0, '0);
    wait_drained();

    run_phase(0, 32'hFFFF, 32'hFFFF, 4, 70, 6, 6, 1'b1, 1'b1);
    run_phase(32'hFFF, 32'hFFFF, 32'hFFFF, 7, 60, 3, 8, 1'b1, 1'b1);
    run_phase(6, 9000, 40000, 1, 70, 5, 5, 1'b0, 1'b1);
    run_phase(0, 0, 0, 0, 50, 4, 4, 1'b1, 1'b0);
    run_phase(($urandom() & 32'hFFFF_F000) | $urandom_range(24), $urandom(), $urandom(),
              $urandom(), 55, 6, 6, 1'b1, 1'b1);
    run_phase(($urandom() & 32'hFFFF_F000) | $urandom_range(24), $urandom(), $urandom(),
              $urandom(), 55, 6, 6, 1'b1, 1'b1);
    run_phase($urandom(), $urandom(), $urandom(), $urandom(), 55, 6, 6, 1'b1, 1'b1);
    run_phase(3, 200, 32'hFFFF, 2, 70, 8, 6, 1'b0, 1'b0);

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
